// ===== hdl/depth_pixel_backprojection_macros.svh =====
// Assertion macros for the depth pixel back-projection block.
// Used by the port checker; needs signals clk and rst_n in scope.
`ifndef DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH

// condition holds at every edge out of reset
`define DPB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// overlapping implication
`define DPB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dpb_pkg.sv =====
// Shared constants for the depth pixel back-projection block.
// No dependencies.
package dpb_pkg;

  localparam int ROW_W   = 12;
  localparam int COL_W   = 12;
  localparam int DEPTH_W = 16;
  localparam int COLOR_W = 8;
  localparam int CFG_W   = 16;
  localparam int COORD_W = 40;
  localparam int Z_W     = 32;

  // image bounds; pixels at or past them give no point
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // offset magnitude in Q.4, product and quotient width of the x/y division
  localparam int OFS_W  = 16;
  localparam int PROD_W = OFS_W + Z_W;

  // one quotient bit per pipeline stage
  localparam int Z_STEPS  = Z_W;
  localparam int XY_STEPS = PROD_W;

  // input register, z divider, multiply register, x/y divider, output register
  localparam int PIPE_LATENCY = 3 + Z_STEPS + XY_STEPS;

  localparam logic [COORD_W-1:0] POS_LIMIT = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] NEG_LIMIT = {1'b1, {(COORD_W-1){1'b0}}};

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd4;

  localparam logic [CFG_W-1:0] CENTER_X_RST    = 16'd5208;
  localparam logic [CFG_W-1:0] CENTER_Y_RST    = 16'd4056;
  localparam logic [CFG_W-1:0] FOCAL_X_RST     = 16'd8288;
  localparam logic [CFG_W-1:0] FOCAL_Y_RST     = 16'd8304;
  localparam logic [CFG_W-1:0] DEPTH_SCALE_RST = 16'd1000;

endpackage

// ===== hdl/dpb_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage,
// LANES dividends in step with one valid chain and a sideband word. No deps.
module dpb_div #(
  parameter int N      = 32,
  parameter int DW     = 16,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [LANES-1:0][N-1:0]    in_num,
  input  logic [LANES-1:0][DW-1:0]   in_den,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][N-1:0]    out_quo,
  output logic [SIDE_W-1:0]          out_side
);

  logic                     vld_r  [1:N];
  logic [LANES-1:0][N-1:0]  work_r [1:N];
  logic [LANES-1:0][DW-1:0] rem_r  [1:N-1];
  logic [SIDE_W-1:0]        side_r [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic                     vld_src;
    logic [LANES-1:0][N-1:0]  work_src;
    logic [LANES-1:0][DW-1:0] rem_src;
    logic [SIDE_W-1:0]        side_src;
    logic [LANES-1:0][N-1:0]  work_nxt;
    logic [LANES-1:0][DW-1:0] rem_nxt;

    if (k == 0) begin : g_head
      assign vld_src  = in_valid;
      assign work_src = in_num;
      assign rem_src  = '0;
      assign side_src = in_side;
    end else begin : g_body
      assign vld_src  = vld_r[k];
      assign work_src = work_r[k];
      assign rem_src  = rem_r[k];
      assign side_src = side_r[k];
    end

    // work holds the unused dividend bits on top, quotient bits shift in below
    always_comb begin : step
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        trial       = {rem_src[l], work_src[l][N-1]};
        diff        = trial - {1'b0, in_den[l]};
        ge          = (trial >= {1'b0, in_den[l]});
        rem_nxt[l]  = ge ? diff[DW-1:0] : trial[DW-1:0];
        work_nxt[l] = {work_src[l][N-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      work_r[k+1] <= work_nxt;
      side_r[k+1] <= side_src;
    end

    if (k < N-1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[k+1] <= rem_nxt;
      end
    end
  end

  assign out_valid = vld_r[N];
  assign out_quo   = work_r[N];
  assign out_side  = side_r[N];

endmodule

// ===== hdl/depth_pixel_backprojection.sv =====
// Top level of the depth pixel back-projection block.
// Uses dpb_pkg and dpb_div.

// Pinhole back-projection of RGB-D pixels into colored 3-D points. One pixel
// can be started in every clock cycle and busy never rises; pixels with zero
// depth or outside the image produce no point. Each point appears on the out_
// ports for one cycle with out_valid; its pixel passes one register at the
// input, the z divider (32 stages, one quotient bit each), one register at
// the multiplier, the x/y divider (48 stages) and one register at the
// output. The receiver cannot stall the block.
// Configuration is always ready; write it only while no pixel is in flight.
module depth_pixel_backprojection #(
  parameter int MAX_WIDTH  = dpb_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = dpb_pkg::MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel command
  input  logic                               start,
  output logic                               busy,
  input  logic [dpb_pkg::ROW_W-1:0]          in_pixel_row,
  input  logic [dpb_pkg::COL_W-1:0]          in_pixel_col,
  input  logic [dpb_pkg::DEPTH_W-1:0]        in_raw_depth,
  input  logic [dpb_pkg::COLOR_W-1:0]        in_blue_in,
  input  logic [dpb_pkg::COLOR_W-1:0]        in_green_in,
  input  logic [dpb_pkg::COLOR_W-1:0]        in_red_in,
  // point result
  output logic                               out_valid,
  output logic signed [dpb_pkg::COORD_W-1:0] out_point_x,
  output logic signed [dpb_pkg::COORD_W-1:0] out_point_y,
  output logic [dpb_pkg::Z_W-1:0]            out_point_z,
  output logic [dpb_pkg::COLOR_W-1:0]        out_blue_out,
  output logic [dpb_pkg::COLOR_W-1:0]        out_green_out,
  output logic [dpb_pkg::COLOR_W-1:0]        out_red_out,
  output logic                               out_clipped,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpb_pkg::CFG_W-1:0]          cfg_data
);

  localparam int OFS_W   = dpb_pkg::OFS_W;
  localparam int Z_W     = dpb_pkg::Z_W;
  localparam int PROD_W  = dpb_pkg::PROD_W;
  localparam int COORD_W = dpb_pkg::COORD_W;
  localparam int CFG_W   = dpb_pkg::CFG_W;

  localparam logic [dpb_pkg::COL_W:0] COL_LIMIT = (dpb_pkg::COL_W+1)'(MAX_WIDTH);
  localparam logic [dpb_pkg::ROW_W:0] ROW_LIMIT = (dpb_pkg::ROW_W+1)'(MAX_HEIGHT);

  typedef struct packed {
    logic                        neg_x;
    logic [OFS_W-1:0]            mag_x;
    logic                        neg_y;
    logic [OFS_W-1:0]            mag_y;
    logic [dpb_pkg::COLOR_W-1:0] blue;
    logic [dpb_pkg::COLOR_W-1:0] green;
    logic [dpb_pkg::COLOR_W-1:0] red;
  } front_t;

  typedef struct packed {
    logic [Z_W-1:0]              z;
    logic                        neg_x;
    logic                        zero_x;
    logic                        neg_y;
    logic                        zero_y;
    logic [dpb_pkg::COLOR_W-1:0] blue;
    logic [dpb_pkg::COLOR_W-1:0] green;
    logic [dpb_pkg::COLOR_W-1:0] red;
  } mid_t;

  // {clip, value}: saturate a quotient magnitude and apply its sign
  function automatic logic [COORD_W:0] sat_axis(input logic [PROD_W-1:0] q,
                                                input logic neg, input logic zero);
    logic [PROD_W-1:0] lim;
    logic [PROD_W-1:0] mag;
    logic              clip;
    lim  = neg ? PROD_W'(dpb_pkg::NEG_LIMIT) : PROD_W'(dpb_pkg::POS_LIMIT);
    mag  = q;
    clip = 1'b0;
    if (zero) begin
      mag = '0;
    end else if (q > lim) begin
      mag  = lim;
      clip = 1'b1;
    end
    sat_axis = {clip, neg ? (COORD_W'(0) - mag[COORD_W-1:0]) : mag[COORD_W-1:0]};
  endfunction

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] center_x_r, center_y_r, focal_x_r, focal_y_r, depth_scale_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= dpb_pkg::CENTER_X_RST;
      center_y_r    <= dpb_pkg::CENTER_Y_RST;
      focal_x_r     <= dpb_pkg::FOCAL_X_RST;
      focal_y_r     <= dpb_pkg::FOCAL_Y_RST;
      depth_scale_r <= dpb_pkg::DEPTH_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dpb_pkg::REG_CENTER_X:    center_x_r    <= cfg_data;
        dpb_pkg::REG_CENTER_Y:    center_y_r    <= cfg_data;
        dpb_pkg::REG_FOCAL_X:     focal_x_r     <= cfg_data;
        dpb_pkg::REG_FOCAL_Y:     focal_y_r     <= cfg_data;
        dpb_pkg::REG_DEPTH_SCALE: depth_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- input stage
  logic                        in_take;
  logic [OFS_W-1:0]            p16_x, p16_y;
  front_t                      front_nxt;
  logic                        in_vld_r;
  front_t                      in_front_r;
  logic [dpb_pkg::DEPTH_W-1:0] in_depth_r;

  assign in_take = start && !busy && (in_raw_depth != '0)
                && ({1'b0, in_pixel_col} < COL_LIMIT)
                && ({1'b0, in_pixel_row} < ROW_LIMIT);

  assign p16_x = {in_pixel_col, 4'b0000};
  assign p16_y = {in_pixel_row, 4'b0000};

  always_comb begin
    front_nxt.neg_x = (p16_x < center_x_r);
    front_nxt.mag_x = front_nxt.neg_x ? (center_x_r - p16_x) : (p16_x - center_x_r);
    front_nxt.neg_y = (p16_y < center_y_r);
    front_nxt.mag_y = front_nxt.neg_y ? (center_y_r - p16_y) : (p16_y - center_y_r);
    front_nxt.blue  = in_blue_in;
    front_nxt.green = in_green_in;
    front_nxt.red   = in_red_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    in_front_r <= front_nxt;
    in_depth_r <= in_raw_depth;
  end

  // -------------------------------------------------------------- z divide
  // zero depth_scale gives an all-ones quotient, as required
  logic                    zdiv_vld;
  logic [0:0][Z_W-1:0]     zdiv_quo;
  logic [$bits(front_t)-1:0] zdiv_side;
  front_t                  zdiv_front;

  dpb_div #(
    .N      (dpb_pkg::Z_STEPS),
    .DW     (CFG_W),
    .LANES  (1),
    .SIDE_W ($bits(front_t))
  ) u_zdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vld_r),
    .in_num    ({in_depth_r, 16'h0000}),
    .in_den    (depth_scale_r),
    .in_side   (in_front_r),
    .out_valid (zdiv_vld),
    .out_quo   (zdiv_quo),
    .out_side  (zdiv_side)
  );

  assign zdiv_front = front_t'(zdiv_side);

  // ------------------------------------------------------------- multiply
  logic              mul_vld_r;
  logic [PROD_W-1:0] mul_prod_x_r, mul_prod_y_r;
  front_t            mul_front_r;
  logic [Z_W-1:0]    mul_z_r;
  mid_t              mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= zdiv_vld;
    end
  end

  always_ff @(posedge clk) begin
    mul_prod_x_r <= {{Z_W{1'b0}}, zdiv_front.mag_x} * {{OFS_W{1'b0}}, zdiv_quo[0]};
    mul_prod_y_r <= {{Z_W{1'b0}}, zdiv_front.mag_y} * {{OFS_W{1'b0}}, zdiv_quo[0]};
    mul_front_r  <= zdiv_front;
    mul_z_r      <= zdiv_quo[0];
  end

  always_comb begin
    mid.z      = mul_z_r;
    mid.neg_x  = mul_front_r.neg_x;
    mid.zero_x = (mul_prod_x_r == '0);
    mid.neg_y  = mul_front_r.neg_y;
    mid.zero_y = (mul_prod_y_r == '0);
    mid.blue   = mul_front_r.blue;
    mid.green  = mul_front_r.green;
    mid.red    = mul_front_r.red;
  end

  // ------------------------------------------------------------ x/y divide
  // lane 1 is x, lane 0 is y; zero focal length gives all ones and saturates
  logic                      xy_vld;
  logic [1:0][PROD_W-1:0]    xy_quo;
  logic [$bits(mid_t)-1:0]   xy_side;
  mid_t                      xy_mid;

  dpb_div #(
    .N      (dpb_pkg::XY_STEPS),
    .DW     (CFG_W),
    .LANES  (2),
    .SIDE_W ($bits(mid_t))
  ) u_xydiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_vld_r),
    .in_num    ({mul_prod_x_r, mul_prod_y_r}),
    .in_den    ({focal_x_r, focal_y_r}),
    .in_side   (mid),
    .out_valid (xy_vld),
    .out_quo   (xy_quo),
    .out_side  (xy_side)
  );

  assign xy_mid = mid_t'(xy_side);

  // --------------------------------------------------------- output stage
  logic [COORD_W:0] sat_x, sat_y;
  logic             out_vld_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [Z_W-1:0]   out_z_r;
  logic [dpb_pkg::COLOR_W-1:0] out_blue_r, out_green_r, out_red_r;
  logic             out_clip_r;

  assign sat_x = sat_axis(xy_quo[1], xy_mid.neg_x, xy_mid.zero_x);
  assign sat_y = sat_axis(xy_quo[0], xy_mid.neg_y, xy_mid.zero_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= xy_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r     <= sat_x[COORD_W-1:0];
    out_y_r     <= sat_y[COORD_W-1:0];
    out_clip_r  <= sat_x[COORD_W] | sat_y[COORD_W];
    out_z_r     <= xy_mid.z;
    out_blue_r  <= xy_mid.blue;
    out_green_r <= xy_mid.green;
    out_red_r   <= xy_mid.red;
  end

  assign out_valid     = out_vld_r;
  assign out_point_x   = out_x_r;
  assign out_point_y   = out_y_r;
  assign out_point_z   = out_z_r;
  assign out_blue_out  = out_blue_r;
  assign out_green_out = out_green_r;
  assign out_red_out   = out_red_r;
  assign out_clipped   = out_clip_r;

endmodule

// ===== hdl/dpb_checker.sv =====
// Port-level checker for depth_pixel_backprojection, bound to the top level.
// Uses dpb_pkg and depth_pixel_backprojection_macros.svh.
`include "depth_pixel_backprojection_macros.svh"

module dpb_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [dpb_pkg::DEPTH_W-1:0]        in_raw_depth,
  input logic                               out_valid,
  input logic signed [dpb_pkg::COORD_W-1:0] out_point_x,
  input logic signed [dpb_pkg::COORD_W-1:0] out_point_y,
  input logic [dpb_pkg::Z_W-1:0]            out_point_z,
  input logic                               out_clipped
);

  logic pix_taken;
  logic x_at_limit;
  logic y_at_limit;

  assign pix_taken  = start && !busy && (in_raw_depth != '0);
  assign x_at_limit = (out_point_x == dpb_pkg::POS_LIMIT)
                   || (out_point_x == dpb_pkg::NEG_LIMIT);
  assign y_at_limit = (out_point_y == dpb_pkg::POS_LIMIT)
                   || (out_point_y == dpb_pkg::NEG_LIMIT);

  // the pixel stream is never held off
  `DPB_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

  // every point comes from a pixel with depth taken a fixed latency earlier
  `DPB_ASSERT_IMPLY(a_point_has_pixel, out_valid, $past(pix_taken, dpb_pkg::PIPE_LATENCY), "point without a matching pixel")

  // nonzero depth always yields a nonzero distance
  `DPB_ASSERT_IMPLY(a_z_nonzero, out_valid, out_point_z != '0, "zero distance on a point")

  // a clipped point has a coordinate sitting at a limit
  `DPB_ASSERT_IMPLY(a_clip_at_limit, out_valid && out_clipped, x_at_limit || y_at_limit, "clip flag without saturated coordinate")

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for depth_pixel_backprojection: directed and random RGB-D pixels
// checked against an in-bench pinhole back-projection predictor.
// Depends on dpb_pkg and the block's RTL only.
module tb;
  import dpb_pkg::*;

  localparam int CYCLE_LIMIT    = 150000;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_PIXELS   = 66;
  // index past the register map; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [Z_W-1:0]            z;
    logic [COLOR_W-1:0]        blue;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        red;
    logic                      clip;
  } point_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  start = 1'b0;
  logic                  busy;
  logic [ROW_W-1:0]      in_pixel_row = '0;
  logic [COL_W-1:0]      in_pixel_col = '0;
  logic [DEPTH_W-1:0]    in_raw_depth = '0;
  logic [COLOR_W-1:0]    in_blue_in = '0;
  logic [COLOR_W-1:0]    in_green_in = '0;
  logic [COLOR_W-1:0]    in_red_in = '0;

  logic                      out_valid;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic [Z_W-1:0]            out_point_z;
  logic [COLOR_W-1:0]        out_blue_out;
  logic [COLOR_W-1:0]        out_green_out;
  logic [COLOR_W-1:0]        out_red_out;
  logic                      out_clipped;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // camera intrinsics as the predictor sees them
  logic [CFG_W-1:0] cam_cx = CENTER_X_RST;
  logic [CFG_W-1:0] cam_cy = CENTER_Y_RST;
  logic [CFG_W-1:0] cam_fx = FOCAL_X_RST;
  logic [CFG_W-1:0] cam_fy = FOCAL_Y_RST;
  logic [CFG_W-1:0] cam_scale = DEPTH_SCALE_RST;

  point_t pending_points[$];

  int mismatches   = 0;
  int pixels_sent  = 0;
  int empty_pixels = 0;
  int points_seen  = 0;
  int clipped_seen = 0;
  int cfg_writes   = 0;
  int burst_left   = 0;
  int cycle_count  = 0;

  depth_pixel_backprojection i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_pixel_row  (in_pixel_row),
    .in_pixel_col  (in_pixel_col),
    .in_raw_depth  (in_raw_depth),
    .in_blue_in    (in_blue_in),
    .in_green_in   (in_green_in),
    .in_red_in     (in_red_in),
    .out_valid     (out_valid),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_point_z   (out_point_z),
    .out_blue_out  (out_blue_out),
    .out_green_out (out_green_out),
    .out_red_out   (out_red_out),
    .out_clipped   (out_clipped),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points outstanding", cycle_count,
               pending_points.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // One axis: offset in Q.4 times z in Q.16, divided by the Q.4 focal length,
  // truncated toward zero on the magnitude and saturated to 40 bits.
  function automatic logic [COORD_W-1:0] project_axis(input logic [11:0] pix,
      input logic [CFG_W-1:0] ctr, input logic [Z_W-1:0] z,
      input logic [CFG_W-1:0] foc, output logic sat);
    logic [63:0] p16, c64, mag, prod, lim, q;
    logic        neg;
    sat  = 1'b0;
    p16  = {48'd0, pix, 4'd0};
    c64  = {48'd0, ctr};
    neg  = p16 < c64;
    mag  = neg ? c64 - p16 : p16 - c64;
    prod = mag * {32'd0, z};
    lim  = neg ? {24'd0, NEG_LIMIT} : {24'd0, POS_LIMIT};
    if (prod == 0)
      return '0;
    if (foc == 0) begin
      q   = lim;
      sat = 1'b1;
    end else begin
      q = prod / {48'd0, foc};
      if (q > lim) begin
        q   = lim;
        sat = 1'b1;
      end
    end
    if (neg)
      q = 64'd0 - q;
    return q[COORD_W-1:0];
  endfunction

  function automatic void backproject(input logic [ROW_W-1:0] row,
      input logic [COL_W-1:0] col, input logic [DEPTH_W-1:0] depth,
      input logic [COLOR_W-1:0] b, g, r, output logic has_pt, output point_t pt);
    logic [63:0] num;
    logic        sat_x, sat_y;
    has_pt = 1'b0;
    pt = '{default: '0};
    if (depth == 0 || int'(col) >= MAX_WIDTH || int'(row) >= MAX_HEIGHT)
      return;
    has_pt = 1'b1;
    if (cam_scale == 0) begin
      pt.z = '1;
    end else begin
      num  = {32'd0, depth, 16'd0} / {48'd0, cam_scale};
      pt.z = num[Z_W-1:0];
    end
    pt.x     = project_axis(col, cam_cx, pt.z, cam_fx, sat_x);
    pt.y     = project_axis(row, cam_cy, pt.z, cam_fy, sat_y);
    pt.blue  = b;
    pt.green = g;
    pt.red   = r;
    pt.clip  = sat_x | sat_y;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    case (idx)
      REG_CENTER_X:    cam_cx = val;
      REG_CENTER_Y:    cam_cy = val;
      REG_FOCAL_X:     cam_fx = val;
      REG_FOCAL_Y:     cam_fy = val;
      REG_DEPTH_SCALE: cam_scale = val;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_field(input string what, input logic [63:0] want, got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("point %0d: %s expected %h, got %h", points_seen, what, want, got);
  endtask

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid) begin
      if (out_clipped === 1'b1)
        clipped_seen++;
      if (pending_points.size() == 0) begin
        flag_field("unexpected point, x", 64'd0, 64'(out_point_x));
      end else begin
        want = pending_points.pop_front();
        if (out_point_x !== want.x)
          flag_field("point_x", 64'(want.x), 64'(out_point_x));
        if (out_point_y !== want.y)
          flag_field("point_y", 64'(want.y), 64'(out_point_y));
        if (out_point_z !== want.z)
          flag_field("point_z", 64'(want.z), 64'(out_point_z));
        if (out_blue_out !== want.blue)
          flag_field("blue", 64'(want.blue), 64'(out_blue_out));
        if (out_green_out !== want.green)
          flag_field("green", 64'(want.green), 64'(out_green_out));
        if (out_red_out !== want.red)
          flag_field("red", 64'(want.red), 64'(out_red_out));
        if (out_clipped !== want.clip)
          flag_field("clipped", 64'(want.clip), 64'(out_clipped));
      end
      points_seen++;
    end
  end

  // ---------------------------------------------------------------- driving

  // Start stays high across back-to-back words; here it only drops when a gap is drawn.
  task automatic send_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
      input logic [DEPTH_W-1:0] depth, input logic [COLOR_W-1:0] b, g, r);
    int     gap;
    logic   has_pt;
    point_t pt;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 15) == 0)
        burst_left = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_pixel_row <= row;
    in_pixel_col <= col;
    in_raw_depth <= depth;
    in_blue_in   <= b;
    in_green_in  <= g;
    in_red_in    <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    backproject(row, col, depth, b, g, r, has_pt, pt);
    if (has_pt)
      pending_points.insert(pending_points.size(), pt);
    else
      empty_pixels++;
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    logic [DEPTH_W-1:0] depth;
    case ($urandom_range(0, 9))
      0:       depth = '0;
      1:       depth = $urandom_range(0, 1) ? '1 : DEPTH_W'(1);
      default: depth = DEPTH_W'($urandom_range(1, 65535));
    endcase
    send_pixel(ROW_W'($urandom_range(0, 4095)), COL_W'($urandom_range(0, 4095)), depth,
               COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
               COLOR_W'($urandom_range(0, 255)));
  endtask

  // zero-depth pixels produce no point and never enter the pipe; after the last
  // point, wait out the full latency as well
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_camera(input logic [CFG_W-1:0] cx, cy, fx, fy, scale);
    wait_idle();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_DEPTH_SCALE, scale);
  endtask

  // ---------------------------------------------------------------- tests

  // Reset intrinsics: image corners, nearest and farthest depth, no-depth pixel.
  // Rows and columns are 12 bits, so a pixel past the image bounds cannot occur.
  task automatic test_reset_intrinsics();
    send_pixel(12'd0, 12'd0, 16'd1, 8'h00, 8'h00, 8'h00);
    send_pixel(12'd4095, 12'd4095, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd253, 12'd325, 16'd1500, 8'h5A, 8'hA5, 8'h3C);
    send_pixel(12'd100, 12'd200, 16'd0, 8'h11, 8'h22, 8'h33);
    send_pixel(12'd4095, 12'd0, 16'hFFFF, 8'h80, 8'h01, 8'hFE);
    send_pixel(12'd0, 12'd4095, 16'd32768, 8'h7F, 8'hC3, 8'h18);
  endtask

  // Unit focal lengths and depth scale: products far past 40 bits saturate.
  task automatic test_saturation();
    set_camera(16'd0, 16'hFFFF, 16'd1, 16'd1, 16'd1);
    send_pixel(12'd0, 12'd4095, 16'hFFFF, 8'h01, 8'h02, 8'h03);
    send_pixel(12'd4095, 12'd0, 16'd1, 8'hFF, 8'h00, 8'hFF);
    send_pixel(12'd2048, 12'd2048, 16'd40000, 8'h44, 8'h55, 8'h66);
    send_pixel(12'd4095, 12'd4095, 16'hFFFF, 8'h00, 8'hFF, 8'h00);
  endtask

  // Zero focal lengths and zero depth scale; the column on the principal point
  // gives x of zero without clipping.
  task automatic test_degenerate_intrinsics();
    set_camera(16'd1600, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    send_pixel(12'd7, 12'd100, 16'd1, 8'h10, 8'h20, 8'h30);
    send_pixel(12'd4095, 12'd4095, 16'hFFFF, 8'hAA, 8'hBB, 8'hCC);
    send_pixel(12'd0, 12'd0, 16'd5, 8'hDE, 8'hAD, 8'hBE);
    send_pixel(12'd9, 12'd9, 16'd0, 8'h00, 8'h00, 8'h00);
  endtask

  // Every register at its largest value.
  task automatic test_max_intrinsics();
    set_camera(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(12'd0, 12'd0, 16'hFFFF, 8'h0F, 8'hF0, 8'h99);
    send_pixel(12'd4095, 12'd4095, 16'd1, 8'h66, 8'h77, 8'h88);
    send_pixel(12'd1234, 12'd3210, 16'd777, 8'h12, 8'h34, 8'h56);
  endtask

  task automatic test_random_frames();
    logic [CFG_W-1:0] cx, cy, fx, fy, scale;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: begin
          // realistic camera
          cx    = CFG_W'($urandom_range(8000, 57000));
          cy    = CFG_W'($urandom_range(8000, 57000));
          fx    = CFG_W'($urandom_range(2000, 20000));
          fy    = CFG_W'($urandom_range(2000, 20000));
          scale = CFG_W'($urandom_range(500, 5000));
        end
        1: begin
          // short focal and tiny scale: heavy clipping
          cx    = CFG_W'($urandom_range(0, 65535));
          cy    = CFG_W'($urandom_range(0, 65535));
          fx    = CFG_W'($urandom_range(0, 64));
          fy    = CFG_W'($urandom_range(0, 64));
          scale = CFG_W'($urandom_range(0, 8));
        end
        default: begin
          cx    = CFG_W'($urandom_range(0, 65535));
          cy    = CFG_W'($urandom_range(0, 65535));
          fx    = CFG_W'($urandom_range(0, 65535));
          fy    = CFG_W'($urandom_range(0, 65535));
          scale = CFG_W'($urandom_range(0, 65535));
        end
      endcase
      set_camera(cx, cy, fx, fy, scale);
      repeat (PHASE_PIXELS) send_random_pixel();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_intrinsics();
    test_saturation();
    test_degenerate_intrinsics();
    test_max_intrinsics();
    test_random_frames();

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_points.size() != 0) begin
      mismatches += pending_points.size();
      $display("%0d expected points never arrived", pending_points.size());
    end

    $display("%0d pixels sent (%0d without depth), %0d points checked, %0d clipped",
             pixels_sent, empty_pixels, points_seen, clipped_seen);
    $display("%0d register writes over %0d camera settings, %0d mismatches",
             cfg_writes, RANDOM_PHASES + 4, mismatches);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== depth_pixel_backprojection.f =====
+incdir+hdl
hdl/dpb_pkg.sv
hdl/dpb_div.sv
hdl/depth_pixel_backprojection.sv
hdl/dpb_checker.sv
sim/tb.sv
